// File: rtl/ppm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_pkg
// shared types, codes and reset values of the ppm frame generator
// ----------------------------------------------------------------------------
package ppm_pkg;

	// item operation codes, carried on s_tuser
	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_WRITE_ONE = 2'd1;
	localparam logic [1:0] OP_WRITE_ALL = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
	localparam logic [1:0] REG_PULSE_LENGTH = 2'd1;
	localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd2;
	localparam logic [1:0] REG_ENABLE       = 2'd3;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned VALUE_W     = 16;
	localparam int unsigned CHAN_W      = 5;
	localparam int unsigned S_TDATA_W   = 24;
	localparam int unsigned M_TDATA_W   = 8;

	localparam logic [15:0] FRAME_LENGTH_RST = 16'd22500;
	localparam logic [15:0] PULSE_LENGTH_RST = 16'd300;
	localparam logic [15:0] CHAN_VALUE_RST   = 16'd1500;
	localparam logic [15:0] COUNTDOWN_RST    = 16'd50;

	typedef struct packed {
		logic [15:0] frame_length;
		logic [15:0] pulse_length;
		logic        active_level;
		logic        enable;
	} cfg_t;

	typedef struct packed {
		logic              in_pulse;
		logic [CHAN_W-1:0] channel_index;
	} status_t;

	// a minus b, floored at one tick
	function automatic logic [15:0] floor_one(input logic [15:0] a, input logic [15:0] b);
		floor_one = (a > b) ? (a - b) : 16'd1;
	endfunction

	// saturating 16-bit add
	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[16] ? 16'hFFFF : s[15:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/ppm_frame_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_frame_generator_top
// rc ppm pulse train generator driven by microsecond tick items
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// s_       in         s_tvalid/s_tready   tuser: op; tdata: channel, value
// m_       out        m_tvalid/m_tready   tdata: pin, pulse_active, current_channel
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one item per cycle while m_tready is high; an item passes the input register, then the result register
// the timing state updates as an item leaves the input register
// a stalled result register holds the input register; s_tready drops only when both are full
// reset loads the configuration, channel interval and timing reset values at once
// ----------------------------------------------------------------------------
module ppm_frame_generator_top #(
	parameter int unsigned NUM_CHANNELS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [ppm_pkg::S_TDATA_W-1:0]     s_tdata,   // channel[4:0], value[20:5]
	input  wire logic [1:0]                        s_tuser,   // op[1:0]
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [ppm_pkg::M_TDATA_W-1:0]          m_tdata,   // pin[0], pulse_active[1], current_channel[6:2]
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ppm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [ppm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ppm_pkg::*;

	cfg_t               cfg;
	status_t            status_next;
	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [CHAN_W-1:0]  channel_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic               advance;
	logic               driving;
	logic [CHAN_W-1:0]  rd_index;
	logic [VALUE_W-1:0] rd_value;

	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	ppm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ppm_chan_store #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_one     (advance && op_s1 == OP_WRITE_ONE),
		.wr_all     (advance && op_s1 == OP_WRITE_ALL),
		.wr_channel (channel_s1),
		.wr_value   (value_s1),
		.rd_index   (rd_index),
		.rd_value   (rd_value)
	);

	ppm_core #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (advance && op_s1 == OP_TICK),
		.cfg         (cfg),
		.chan_value  (rd_value),
		.rd_index    (rd_index),
		.status_next (status_next)
	);

	assign driving = cfg.enable && status_next.in_pulse;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1      <= s_tuser;
			channel_s1 <= s_tdata[CHAN_W-1:0];
			value_s1   <= s_tdata[CHAN_W +: VALUE_W];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (!m_tvalid_q || m_tready) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {1'b0, status_next.channel_index, driving,
				driving ? cfg.active_level : ~cfg.active_level};
		end
	end

endmodule
`default_nettype wire

// File: rtl/ppm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_cfg_regs
// configuration register file written through the cfg channel
// ----------------------------------------------------------------------------
module ppm_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ppm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [ppm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ppm_pkg::cfg_t                           cfg
);
	import ppm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_length <= FRAME_LENGTH_RST;
			cfg_q.pulse_length <= PULSE_LENGTH_RST;
			cfg_q.active_level <= 1'b1;
			cfg_q.enable       <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_LENGTH: cfg_q.frame_length <= cfg_data;
				REG_PULSE_LENGTH: cfg_q.pulse_length <= cfg_data;
				REG_ACTIVE_LEVEL: cfg_q.active_level <= cfg_data[0];
				REG_ENABLE:       cfg_q.enable       <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/ppm_chan_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_chan_store
// per-channel interval registers with single and broadcast write
// ----------------------------------------------------------------------------
module ppm_chan_store #(
	parameter int unsigned NUM_CHANNELS = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_one,
	input  wire logic                             wr_all,
	input  wire logic [ppm_pkg::CHAN_W-1:0]       wr_channel,
	input  wire logic [ppm_pkg::VALUE_W-1:0]      wr_value,
	input  wire logic [ppm_pkg::CHAN_W-1:0]       rd_index,
	output logic [ppm_pkg::VALUE_W-1:0]           rd_value
);
	import ppm_pkg::*;

	localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [VALUE_W-1:0] value_q [NUM_CHANNELS];

	assign rd_value = value_q[rd_index[IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				value_q[i] <= CHAN_VALUE_RST;
			end
		end else begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (wr_all || (wr_one && (wr_channel == CHAN_W'(i + 1)))) begin
					value_q[i] <= wr_value;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/ppm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_core
// pulse and gap timing: countdown, pulse phase, channel index, frame sum
// ----------------------------------------------------------------------------
module ppm_core #(
	parameter int unsigned NUM_CHANNELS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          tick,
	input  wire ppm_pkg::cfg_t                 cfg,
	input  wire logic [ppm_pkg::VALUE_W-1:0]   chan_value,
	output logic [ppm_pkg::CHAN_W-1:0]         rd_index,
	output ppm_pkg::status_t                   status_next
);
	import ppm_pkg::*;

	logic              in_pulse_q, in_pulse_d;
	logic [15:0]       countdown_q, countdown_d;
	logic [CHAN_W-1:0] channel_index_q, channel_index_d;
	logic [15:0]       running_sum_q, running_sum_d;
	logic [15:0]       used;

	assign rd_index = channel_index_q;
	assign used     = sat_add(running_sum_q, cfg.pulse_length);

	always_comb begin
		in_pulse_d      = in_pulse_q;
		countdown_d     = countdown_q;
		channel_index_d = channel_index_q;
		running_sum_d   = running_sum_q;
		if (tick && cfg.enable) begin
			if (countdown_q <= 16'd1) begin
				if (!in_pulse_q) begin
					in_pulse_d  = 1'b1;
					countdown_d = (cfg.pulse_length == 16'd0) ? 16'd1 : cfg.pulse_length;
				end else begin
					in_pulse_d = 1'b0;
					if (channel_index_q < CHAN_W'(NUM_CHANNELS)) begin
						countdown_d     = floor_one(chan_value, cfg.pulse_length);
						running_sum_d   = sat_add(running_sum_q, chan_value);
						channel_index_d = channel_index_q + CHAN_W'(1);
					end else begin
						countdown_d     = floor_one(cfg.frame_length, used);
						channel_index_d = '0;
						running_sum_d   = '0;
					end
				end
			end else begin
				countdown_d = countdown_q - 16'd1;
			end
		end
	end

	assign status_next.in_pulse      = in_pulse_d;
	assign status_next.channel_index = channel_index_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pulse_q      <= 1'b0;
			countdown_q     <= COUNTDOWN_RST;
			channel_index_q <= '0;
			running_sum_q   <= '0;
		end else begin
			in_pulse_q      <= in_pulse_d;
			countdown_q     <= countdown_d;
			channel_index_q <= channel_index_d;
			running_sum_q   <= running_sum_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_countdown_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		countdown_q != 16'd0)
		else $error("countdown reached zero without reload");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		channel_index_q <= CHAN_W'(NUM_CHANNELS))
		else $error("channel index beyond channel count");

	a_sync_clears_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && cfg.enable && in_pulse_q && countdown_q <= 16'd1
			&& channel_index_q == CHAN_W'(NUM_CHANNELS))
		|=> (running_sum_q == 16'd0 && channel_index_q == '0 && !in_pulse_q))
		else $error("sync gap did not restart the frame");

	a_disabled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!cfg.enable) |=> (countdown_q == $past(countdown_q)
			&& in_pulse_q == $past(in_pulse_q)))
		else $error("timing state moved while disabled");
`endif

endmodule
`default_nettype wire
